@@ src/cdqs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the circular deque with search.
// No dependencies; used by cdqs_cell and circular_deque_with_search.
package cdqs_pkg;

  localparam int ID_W     = 32;
  localparam int STATUS_W = 2;
  localparam int IN_W     = 40;  // func + item_id, padded to whole bytes
  localparam int OUT_W    = 40;  // status + data_out, padded to whole bytes

  typedef enum logic [2:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_BACK  = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_SEARCH     = 3'd4,
    FUNC_LIST       = 3'd5
  } func_t;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_FRONT,
    CELL_PUSH_BACK,
    CELL_POP_FRONT,
    CELL_ROTATE
  } cell_op_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    cell_op_t          op;
    logic [ID_W-1:0]   id;
  } cell_cmd_t;

  function automatic logic [OUT_W-1:0] pack_out(input logic [STATUS_W-1:0] status,
                                                input logic [ID_W-1:0] data);
    pack_out = {{(OUT_W - ID_W - STATUS_W){1'b0}}, data, status};
  endfunction

endpackage

@@ src/cdqs_cell.sv @@
`timescale 1ns / 1ps
// One storage cell of the deque chain: holds one id, shifts to or from its neighbours.
// Depends on cdqs_pkg.
module cdqs_cell #(
  parameter int DEPTH = 16,
  parameter int IDX   = 0
) (
  input  logic                           clk,
  input  cdqs_pkg::cell_cmd_t            cmd,
  input  logic [$clog2(DEPTH+1)-1:0]     cnt,
  input  logic [cdqs_pkg::ID_W-1:0]      left,
  input  logic [cdqs_pkg::ID_W-1:0]      right,
  input  logic [cdqs_pkg::ID_W-1:0]      wrap,
  output logic [cdqs_pkg::ID_W-1:0]      q
);

  localparam int CW = $clog2(DEPTH+1);
  localparam logic [CW-1:0] POS = CW'(IDX);

  logic [cdqs_pkg::ID_W-1:0] q_next;
  logic [CW-1:0]             cnt_m1;

  assign cnt_m1 = cnt - CW'(1);

  always_comb begin
    q_next = q;
    case (cmd.op)
      cdqs_pkg::CELL_HOLD: ;
      cdqs_pkg::CELL_PUSH_FRONT: q_next = (POS == '0) ? cmd.id : left;
      cdqs_pkg::CELL_PUSH_BACK: begin
        if (POS == cnt) q_next = cmd.id;
      end
      cdqs_pkg::CELL_POP_FRONT: q_next = right;
      // rotate the occupied run by one: front goes round to the tail
      cdqs_pkg::CELL_ROTATE: begin
        if (POS == cnt_m1) q_next = wrap;
        else if (POS < cnt_m1) q_next = right;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

@@ src/circular_deque_with_search.sv @@
`timescale 1ns / 1ps
// Bounded deque of 32-bit ids held in a chain of DEPTH cells, front in cell 0.
// Depends on cdqs_pkg and cdqs_cell.
//
// Push front/back and pop front/back each give one transaction; a new item
// may follow in the next cycle when the result is taken. Search and list walk
// the stored entries by rotating the occupied run through cell 0, one entry
// per cycle after the accepting cycle; a list walk pauses while the downstream
// side does not take results. A list gives one result per walk cycle while the
// downstream side takes them, so the next item can be taken once the last
// result of the list is taken. A search walks every entry and then delivers
// its single result. Downstream stalls delay both. The walk always runs the
// full count, leaving the order as it was. A push onto a full store returns
// status full; pops, searches and lists of an empty store return status empty.
// Selectors 6 and 7 are consumed with no result.
module circular_deque_with_search #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [cdqs_pkg::IN_W-1:0]   s_tdata,   // [2:0] func, [34:3] item_id
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [cdqs_pkg::OUT_W-1:0]  m_tdata,   // [1:0] status, [33:2] data_out
  output logic                        m_tlast
);

  localparam int CW = $clog2(DEPTH+1);
  localparam int IW = $clog2(DEPTH);

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FOUND} state_t;

  state_t                      state;
  logic [CW-1:0]               cnt;
  logic [CW-1:0]               k;
  logic                        op_list;
  logic                        found;
  logic [cdqs_pkg::ID_W-1:0]   key;
  logic [cdqs_pkg::ID_W-1:0]   hit;

  logic [cdqs_pkg::ID_W-1:0]   cell_q [DEPTH];
  cdqs_pkg::cell_cmd_t         cmd;
  cdqs_pkg::func_t             func;
  logic [cdqs_pkg::ID_W-1:0]   in_id;
  logic [CW-1:0]               cnt_m1;
  logic                        in_fire;
  logic                        out_free;
  logic                        full;
  logic                        empty;
  logic                        walk_end;

  assign func     = cdqs_pkg::func_t'(s_tdata[2:0]);
  assign in_id    = s_tdata[34:3];
  assign cnt_m1   = cnt - CW'(1);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign in_fire  = s_tvalid && s_tready;
  assign full     = (cnt == CW'(DEPTH));
  assign empty    = (cnt == '0);
  assign walk_end = (k == cnt_m1);

  always_comb begin
    cmd.op = cdqs_pkg::CELL_HOLD;
    cmd.id = in_id;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (func)
            cdqs_pkg::FUNC_PUSH_FRONT: if (!full) cmd.op = cdqs_pkg::CELL_PUSH_FRONT;
            cdqs_pkg::FUNC_PUSH_BACK:  if (!full) cmd.op = cdqs_pkg::CELL_PUSH_BACK;
            cdqs_pkg::FUNC_POP_FRONT:  if (!empty) cmd.op = cdqs_pkg::CELL_POP_FRONT;
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (!op_list || out_free) cmd.op = cdqs_pkg::CELL_ROTATE;
      end
      default: ;
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [cdqs_pkg::ID_W-1:0] left_d;
    logic [cdqs_pkg::ID_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid
      assign left_d = cell_q[i-1];
    end
    if (i == DEPTH-1) begin : g_last
      assign right_d = cell_q[i];
    end else begin : g_inner
      assign right_d = cell_q[i+1];
    end
    cdqs_cell #(.DEPTH(DEPTH), .IDX(i)) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .cnt   (cnt),
      .left  (left_d),
      .right (right_d),
      .wrap  (cell_q[0]),
      .q     (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      k        <= '0;
      op_list  <= 1'b0;
      found    <= 1'b0;
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
    end else begin
      if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            case (func)
              cdqs_pkg::FUNC_PUSH_FRONT, cdqs_pkg::FUNC_PUSH_BACK: begin
                m_tvalid <= 1'b1;
                m_tlast  <= 1'b1;
                m_tdata  <= cdqs_pkg::pack_out(full ? cdqs_pkg::STATUS_FULL
                                                    : cdqs_pkg::STATUS_OK, '0);
                if (!full) cnt <= cnt + CW'(1);
              end
              cdqs_pkg::FUNC_POP_FRONT, cdqs_pkg::FUNC_POP_BACK: begin
                m_tvalid <= 1'b1;
                m_tlast  <= 1'b1;
                if (empty) begin
                  m_tdata <= cdqs_pkg::pack_out(cdqs_pkg::STATUS_EMPTY, '0);
                end else begin
                  m_tdata <= cdqs_pkg::pack_out(cdqs_pkg::STATUS_OK,
                               (func == cdqs_pkg::FUNC_POP_FRONT) ? cell_q[0]
                                                                  : cell_q[cnt_m1[IW-1:0]]);
                  cnt <= cnt_m1;
                end
              end
              cdqs_pkg::FUNC_SEARCH, cdqs_pkg::FUNC_LIST: begin
                if (empty) begin
                  m_tvalid <= 1'b1;
                  m_tlast  <= 1'b1;
                  m_tdata  <= cdqs_pkg::pack_out(cdqs_pkg::STATUS_EMPTY, '0);
                end else begin
                  state   <= ST_WALK;
                  op_list <= (func == cdqs_pkg::FUNC_LIST);
                  key     <= in_id;
                  found   <= 1'b0;
                  k       <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_WALK: begin
          if (op_list) begin
            if (out_free) begin
              m_tvalid <= 1'b1;
              m_tlast  <= walk_end;
              m_tdata  <= cdqs_pkg::pack_out(cdqs_pkg::STATUS_OK, cell_q[0]);
              k        <= k + CW'(1);
              if (walk_end) state <= ST_IDLE;
            end
          end else begin
            // first match wins; keep rotating to restore the order
            if (!found && cell_q[0] == key) begin
              found <= 1'b1;
              hit   <= cell_q[0];
            end
            k <= k + CW'(1);
            if (walk_end) state <= ST_FOUND;
          end
        end
        ST_FOUND: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tlast  <= 1'b1;
            m_tdata  <= found ? cdqs_pkg::pack_out(cdqs_pkg::STATUS_OK, hit)
                              : cdqs_pkg::pack_out(cdqs_pkg::STATUS_NOTFOUND, '0);
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_walk_keeps_cnt: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |=> (cnt == $past(cnt)))
    else $error("entry count changed during a walk");

  a_walk_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (k < cnt))
    else $error("walk step past the occupied run");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] != cdqs_pkg::STATUS_OK) |-> (m_tdata[33:2] == '0 && m_tlast))
    else $error("error transaction with data or without tlast");

endmodule
